/* rtl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int ID_W          = 16;
   localparam int PRIO_W        = 8;
   localparam int POS_W         = 4;
   localparam int FIELD_CNT_W   = 5;
   localparam int DEFAULT_DEPTH = 16;

   typedef enum logic [1:0] {
      OP_INSERT      = 2'd0,
      OP_REMOVE_PRIO = 2'd1,
      OP_REMOVE_MAX  = 2'd2,
      OP_READ        = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic [ID_W-1:0]         key_id;
      logic [PRIO_W-1:0]       key_prio;
   } cell_cmd_type;

endpackage

/* rtl/spq_cell.sv */
// One storage cell of the sorted chain: holds an id and a priority.
// Depends on spq_pkg for the command struct and field widths.
`timescale 1ns / 1ps

module spq_cell (
   input  logic                        clock,
   input  spq_pkg::cell_cmd_type       cmd,
   input  logic                        occupied,
   input  logic                        left_gt,
   input  logic [spq_pkg::ID_W-1:0]    left_id,
   input  logic [spq_pkg::PRIO_W-1:0]  left_prio,
   input  logic [spq_pkg::ID_W-1:0]    right_id,
   input  logic [spq_pkg::PRIO_W-1:0]  right_prio,
   output logic [spq_pkg::ID_W-1:0]    cell_id,
   output logic [spq_pkg::PRIO_W-1:0]  cell_prio,
   output logic                        cell_gt,
   output logic                        cell_match
);

   logic [spq_pkg::ID_W-1:0]   id_ff;
   logic [spq_pkg::ID_W-1:0]   id_in;
   logic [spq_pkg::PRIO_W-1:0] prio_ff;
   logic [spq_pkg::PRIO_W-1:0] prio_in;

   assign cell_gt    = !occupied || (prio_ff > cmd.key_prio);
   assign cell_match = occupied && (prio_ff == cmd.key_prio);
   assign cell_id    = id_ff;
   assign cell_prio  = prio_ff;

   always_comb begin
      id_in   = id_ff;
      prio_in = prio_ff;
      case (cmd.op)
         spq_pkg::CELL_INSERT: begin
            if (cell_gt) begin
               if (left_gt) begin
                  id_in   = left_id;
                  prio_in = left_prio;
               end else begin
                  id_in   = cmd.key_id;
                  prio_in = cmd.key_prio;
               end
            end
         end
         spq_pkg::CELL_SHIFT: begin
            if (occupied && (prio_ff >= cmd.key_prio)) begin
               id_in   = right_id;
               prio_in = right_prio;
            end
         end
         default: begin
            id_in   = id_ff;
            prio_in = prio_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

endmodule

/* rtl/sorted_priority_queue.sv */
// Sorted priority queue: sequencer plus a chain of spq_cell storage cells.
// Depends on spq_pkg and spq_cell.
//
//   channel  dir  handshake          payload
//   req      in   req_tvalid/tready  tuser opcode; tdata id, priority, position
//   rsp      out  rsp_tvalid/tready  tuser status; tdata occupancy, removed, id, prio
//
// Insert, read and a removal on an empty queue pass through S_EXEC and S_FINISH
// from accept to a registered response.
// A removal of k entries (k up to DEPTH) adds S_COMPACT between the two, where
// the cell chain shifts left by one cell per cycle while a match remains.
// Synchronous reset empties the queue; no clearing pass is needed.
// A stalled response holds the sequencer before hand-off; one request is in
// flight at a time, and a new request is taken while the last response waits.
`timescale 1ns / 1ps

module sorted_priority_queue #(
   parameter int DEPTH = spq_pkg::DEFAULT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // opcode
   input  logic [31:0] req_tdata,   // proc_id, priority_req, position, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // status
   output logic [39:0] rsp_tdata    // occupancy, removed_count, read_id, read_priority, pad
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ID_W   = spq_pkg::ID_W;
   localparam int PRIO_W = spq_pkg::PRIO_W;
   localparam int POS_W  = spq_pkg::POS_W;
   localparam int FCW    = spq_pkg::FIELD_CNT_W;
   localparam int RSP_W  = 2 * FCW + ID_W + PRIO_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_COMPACT,
      S_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         removed_ff, removed_in;
   spq_pkg::opcode_type      op_ff, op_in;
   logic [ID_W-1:0]          id_ff, id_in;
   logic [PRIO_W-1:0]        key_ff, key_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   spq_pkg::status_type      status_ff, status_in;
   logic [ID_W-1:0]          rid_ff, rid_in;
   logic [PRIO_W-1:0]        rprio_ff, rprio_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type      rsp_status_ff, rsp_status_in;
   logic [RSP_W-1:0]         rsp_data_ff, rsp_data_in;

   spq_pkg::cell_cmd_type    cmd;
   logic [ID_W-1:0]          cell_id    [DEPTH];
   logic [PRIO_W-1:0]        cell_prio  [DEPTH];
   logic [DEPTH-1:0]         cell_gt;
   logic [DEPTH-1:0]         cell_match;
   logic                     any_match;
   logic [IDX_W-1:0]         tap_idx;
   logic [ID_W-1:0]          tap_id;
   logic [PRIO_W-1:0]        tap_prio;
   logic                     pos_in_range;
   logic                     req_accept;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic             occupied;
      logic             left_gt;
      logic [ID_W-1:0]  left_id;
      logic [PRIO_W-1:0] left_prio;
      logic [ID_W-1:0]  right_id;
      logic [PRIO_W-1:0] right_prio;

      assign occupied = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_gt   = 1'b0;
         assign left_id   = '0;
         assign left_prio = '0;
      end else begin : g_body
         assign left_gt   = cell_gt[i-1];
         assign left_id   = cell_id[i-1];
         assign left_prio = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_id   = cell_id[i];
         assign right_prio = cell_prio[i];
      end else begin : g_next
         assign right_id   = cell_id[i+1];
         assign right_prio = cell_prio[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (occupied),
         .left_gt    (left_gt),
         .left_id    (left_id),
         .left_prio  (left_prio),
         .right_id   (right_id),
         .right_prio (right_prio),
         .cell_id    (cell_id[i]),
         .cell_prio  (cell_prio[i]),
         .cell_gt    (cell_gt[i]),
         .cell_match (cell_match[i])
      );
   end

   assign any_match    = |cell_match;
   assign tap_idx      = (op_ff == spq_pkg::OP_READ) ? IDX_W'(pos_ff)
                                                     : IDX_W'(count_ff - CNT_W'(1));
   assign tap_id       = cell_id[tap_idx];
   assign tap_prio     = cell_prio[tap_idx];
   assign pos_in_range = (32'(pos_ff) < 32'(count_ff));

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(40 - RSP_W){1'b0}}, rsp_data_ff};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      removed_in    = removed_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      rid_in        = rid_ff;
      rprio_in      = rprio_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      cmd.op        = spq_pkg::CELL_HOLD;
      cmd.key_id    = id_ff;
      cmd.key_prio  = key_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in      = spq_pkg::opcode_type'(req_tuser);
               id_in      = req_tdata[ID_W-1:0];
               key_in     = req_tdata[ID_W +: PRIO_W];
               pos_in     = req_tdata[ID_W + PRIO_W +: POS_W];
               removed_in = '0;
               status_in  = spq_pkg::ST_OK;
               rid_in     = '0;
               rprio_in   = '0;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
            unique case (op_ff)
               spq_pkg::OP_INSERT: begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     status_in = spq_pkg::ST_OVERFLOW;
                  end else begin
                     cmd.op   = spq_pkg::CELL_INSERT;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               spq_pkg::OP_REMOVE_PRIO: begin
                  if (count_ff == '0) begin
                     status_in = spq_pkg::ST_EMPTY;
                  end else begin
                     state_in = S_COMPACT;
                  end
               end
               spq_pkg::OP_REMOVE_MAX: begin
                  if (count_ff == '0) begin
                     status_in = spq_pkg::ST_EMPTY;
                  end else begin
                     key_in   = tap_prio;
                     state_in = S_COMPACT;
                  end
               end
               spq_pkg::OP_READ: begin
                  if (pos_in_range) begin
                     rid_in   = tap_id;
                     rprio_in = tap_prio;
                  end else begin
                     status_in = spq_pkg::ST_RANGE;
                  end
               end
               default: begin
                  status_in = spq_pkg::ST_OK;
               end
            endcase
         end
         S_COMPACT: begin
            if (any_match) begin
               cmd.op     = spq_pkg::CELL_SHIFT;
               count_in   = count_ff - CNT_W'(1);
               removed_in = removed_ff + CNT_W'(1);
            end else begin
               if (removed_ff == '0) begin
                  status_in = spq_pkg::ST_EMPTY;
               end
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = {rprio_ff, rid_ff, FCW'(removed_ff), FCW'(count_ff)};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      removed_ff    <= removed_in;
      op_ff         <= op_in;
      id_ff         <= id_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      rid_ff        <= rid_in;
      rprio_ff      <= rprio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy beyond depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && op_ff == spq_pkg::OP_INSERT && count_ff != CNT_W'(DEPTH))
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow occupancy");

   a_compact_conserves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMPACT)
      |=> (count_ff + removed_ff) == $past(count_ff + removed_ff))
      else $error("compaction lost or invented entries");

endmodule

/* tb/tb_sorted_priority_queue.sv */
// Self-checking testbench for sorted_priority_queue: bursty request driver, stalling
// response monitor and a sorted-store predictor of occupancy, removals and reads.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

   localparam int QDEPTH      = spq_pkg::DEFAULT_DEPTH;
   localparam int ID_W        = spq_pkg::ID_W;
   localparam int PRIO_W      = spq_pkg::PRIO_W;
   localparam int POS_W       = spq_pkg::POS_W;
   localparam int FIELD_CNT_W = spq_pkg::FIELD_CNT_W;
   localparam int RAND_REQS   = 2000;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      spq_pkg::opcode_type op;
      logic [ID_W-1:0]     id;
      logic [PRIO_W-1:0]   prio;
      logic [POS_W-1:0]    pos;
   } sched_req_type;

   typedef struct {
      spq_pkg::status_type    status;
      logic [FIELD_CNT_W-1:0] occupancy;
      logic [FIELD_CNT_W-1:0] removed;
      logic [ID_W-1:0]        rd_id;
      logic [PRIO_W-1:0]      rd_prio;
   } sched_rsp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = '0;   // opcode
   logic [31:0] req_tdata  = '0;   // proc_id, priority_req, position, zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;         // status
   logic [39:0] rsp_tdata;         // occupancy, removed_count, read_id, read_priority, pad

   sched_req_type pending_reqs[$];
   sched_rsp_type expected_rsps[$];
   sched_req_type req_cur;
   logic       req_accepted = 1'b0;
   int         burst_left   = 1;
   int         gap_left     = 0;
   int         stall_left   = 0;
   int         mismatch_count = 0;
   int         cycle_count  = 0;

   logic [ID_W-1:0]        store_ids   [QDEPTH];
   logic [PRIO_W-1:0]      store_prios [QDEPTH];
   int                     store_count = 0;

   sorted_priority_queue #(.DEPTH(QDEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   task automatic apply_queue_op(input sched_req_type r, output sched_rsp_type e);
      int slot;
      int i;
      int w;
      logic [PRIO_W-1:0] target;
      e.status  = spq_pkg::ST_OK;
      e.removed = '0;
      e.rd_id   = '0;
      e.rd_prio = '0;
      case (r.op) inside
         spq_pkg::OP_INSERT: begin
            if (store_count >= QDEPTH) begin
               e.status = spq_pkg::ST_OVERFLOW;
            end else begin
               slot = store_count;
               for (i = store_count - 1; i >= 0; i--) begin
                  if (store_prios[i] > r.prio) slot = i;
               end
               for (i = store_count; i > slot; i--) begin
                  store_ids[i]   = store_ids[i-1];
                  store_prios[i] = store_prios[i-1];
               end
               store_ids[slot]   = r.id;
               store_prios[slot] = r.prio;
               store_count++;
            end
         end
         spq_pkg::OP_REMOVE_PRIO, spq_pkg::OP_REMOVE_MAX: begin
            if (store_count == 0) begin
               e.status = spq_pkg::ST_EMPTY;
            end else begin
               target = (r.op == spq_pkg::OP_REMOVE_PRIO) ? r.prio
                                                          : store_prios[store_count-1];
               w = 0;
               for (i = 0; i < store_count; i++) begin
                  if (store_prios[i] != target) begin
                     store_ids[w]   = store_ids[i];
                     store_prios[w] = store_prios[i];
                     w++;
                  end
               end
               e.removed = FIELD_CNT_W'(store_count - w);
               store_count = w;
               if (e.removed == 0) e.status = spq_pkg::ST_EMPTY;
            end
         end
         default: begin
            if (int'(r.pos) < store_count) begin
               e.rd_id   = store_ids[r.pos];
               e.rd_prio = store_prios[r.pos];
            end else begin
               e.status = spq_pkg::ST_RANGE;
            end
         end
      endcase
      e.occupancy = FIELD_CNT_W'(store_count);
   endtask

   task automatic check_rsp(input sched_rsp_type e, input sched_rsp_type a);
      if (e.status != a.status) begin
         $display("%0t status: expected %0d, actual %0d", $time, e.status, a.status);
         mismatch_count++;
      end
      if (e.occupancy != a.occupancy) begin
         $display("%0t occupancy: expected %0d, actual %0d", $time, e.occupancy, a.occupancy);
         mismatch_count++;
      end
      if (e.removed != a.removed) begin
         $display("%0t removed_count: expected %0d, actual %0d", $time, e.removed, a.removed);
         mismatch_count++;
      end
      if (e.rd_id != a.rd_id) begin
         $display("%0t read_id: expected %h, actual %h", $time, e.rd_id, a.rd_id);
         mismatch_count++;
      end
      if (e.rd_prio != a.rd_prio) begin
         $display("%0t read_priority: expected %h, actual %h", $time, e.rd_prio, a.rd_prio);
         mismatch_count++;
      end
   endtask

   function automatic sched_req_type make_req(spq_pkg::opcode_type op,
                                              logic [ID_W-1:0] id,
                                              logic [PRIO_W-1:0] prio,
                                              logic [POS_W-1:0] pos);
      sched_req_type r;
      r.op   = op;
      r.id   = id;
      r.prio = prio;
      r.pos  = pos;
      return r;
   endfunction

   function automatic logic [PRIO_W-1:0] rand_prio();
      if ($urandom_range(0, 1) == 0) return PRIO_W'($urandom_range(0, 7) * 36);
      return PRIO_W'($urandom_range(0, 255));
   endfunction

   always @(posedge clock) begin : rsp_monitor
      sched_rsp_type got;
      sched_rsp_type want;
      req_accepted <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status    = spq_pkg::status_type'(rsp_tuser);
            got.occupancy = rsp_tdata[4:0];
            got.removed   = rsp_tdata[9:5];
            got.rd_id     = rsp_tdata[25:10];
            got.rd_prio   = rsp_tdata[33:26];
            if (expected_rsps.size() == 0) begin
               $display("%0t unexpected response: expected none, actual status %0d occ %0d",
                        $time, got.status, got.occupancy);
               mismatch_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_rsp(want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            apply_queue_op(req_cur, want);
            expected_rsps.push_back(want);
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && (req_accepted || !req_tvalid)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_cur = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= req_cur.op;
            req_tdata  <= {4'b0, req_cur.pos, req_cur.prio, req_cur.id};
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : rsp_stall
      logic next_ready;
      if (stall_left == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               next_ready = 1'b1;
               stall_left = $urandom_range(20, 60);
            end
            1: begin
               next_ready = 1'b0;
               stall_left = $urandom_range(1, 30);
            end
            default: begin
               next_ready = 1'($urandom_range(0, 1));
               stall_left = $urandom_range(1, 4);
            end
         endcase
         rsp_tready <= next_ready;
      end else begin
         stall_left--;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      int i;
      int k;
      int ins_weight;
      int sel;
      spq_pkg::opcode_type op;

      // empty-store corner cases
      pending_reqs.push_back(make_req(spq_pkg::OP_READ, 16'h0, 8'h0, 4'd0));
      pending_reqs.push_back(make_req(spq_pkg::OP_REMOVE_MAX, 16'h0, 8'h0, 4'd0));
      pending_reqs.push_back(make_req(spq_pkg::OP_REMOVE_PRIO, 16'hffff, 8'h05, 4'hf));
      // fill to capacity with extremes and repeated priorities
      for (i = 0; i < QDEPTH; i++) begin
         if (i == 0)
            pending_reqs.push_back(make_req(spq_pkg::OP_INSERT, 16'hffff, 8'hff, 4'hf));
         else if (i == 1)
            pending_reqs.push_back(make_req(spq_pkg::OP_INSERT, 16'h0000, 8'h00, 4'h0));
         else
            pending_reqs.push_back(make_req(spq_pkg::OP_INSERT, ID_W'($urandom),
                                            PRIO_W'((i % 3) * 100), 4'h0));
      end
      pending_reqs.push_back(make_req(spq_pkg::OP_INSERT, 16'h5a5a, 8'h10, 4'h0));
      pending_reqs.push_back(make_req(spq_pkg::OP_READ, 16'h0, 8'h0, 4'hf));
      pending_reqs.push_back(make_req(spq_pkg::OP_READ, 16'h0, 8'h0, 4'h0));
      pending_reqs.push_back(make_req(spq_pkg::OP_REMOVE_PRIO, 16'h0, 8'd77, 4'h0));
      pending_reqs.push_back(make_req(spq_pkg::OP_REMOVE_MAX, 16'h0, 8'h0, 4'h0));
      pending_reqs.push_back(make_req(spq_pkg::OP_REMOVE_PRIO, 16'h0, 8'd100, 4'h0));
      pending_reqs.push_back(make_req(spq_pkg::OP_READ, 16'h0, 8'h0, 4'hf));

      // alternate fill-heavy and drain-heavy phases
      for (i = 0; i < RAND_REQS; i += 40) begin
         ins_weight = ((i / 40) % 2 == 0) ? 75 : 30;
         for (k = 0; k < 40; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < ins_weight)
               op = spq_pkg::OP_INSERT;
            else if (sel < ins_weight + (100 - ins_weight) / 2)
               op = spq_pkg::OP_READ;
            else if ($urandom_range(0, 1) == 0)
               op = spq_pkg::OP_REMOVE_PRIO;
            else
               op = spq_pkg::OP_REMOVE_MAX;
            pending_reqs.push_back(make_req(op, ID_W'($urandom), rand_prio(),
                                            POS_W'($urandom_range(0, 15))));
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_reqs.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
